@@ design/prt_pkg.sv @@
// Shared types and codes for the pending request tracker.
package prt_pkg;

	// Fixed field widths of the command and result ports
	localparam int ACTION_W     = 2;
	localparam int SEQ_W        = 8;
	localparam int HANDLE_IN_W  = 16;
	localparam int STATUS_W     = 2;
	localparam int HANDLE_OUT_W = 16;
	localparam int COUNT_OUT_W  = 5;

	// Command codes
	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_FLUSH  = 2'd3;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

	// Per-cell control: load from the command, or take the right neighbor's entry
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

	// Sequencer states, one-hot
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_EXEC  = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

endpackage

@@ design/prt_cell.sv @@
// One table cell: holds one entry, compares its sequence number, shifts left on demand.
module prt_cell #(
	parameter int HANDLE_BITS = 16
) (
	input  logic                       clk,
	input  prt_pkg::cell_ctl_t         ctl,
	input  logic [prt_pkg::SEQ_W-1:0]  cmp_seq,
	input  logic [prt_pkg::SEQ_W-1:0]  load_seq,
	input  logic [HANDLE_BITS-1:0]     load_handle,
	input  logic [prt_pkg::SEQ_W-1:0]  next_seq,
	input  logic [HANDLE_BITS-1:0]     next_handle,
	output logic [prt_pkg::SEQ_W-1:0]  seq,
	output logic [HANDLE_BITS-1:0]     handle,
	output logic                       hit
);
	import prt_pkg::*;

	logic [SEQ_W-1:0]       seq_q;
	logic [HANDLE_BITS-1:0] handle_q;

	// Entry storage: a shift from the neighbor wins over a load (never both)
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			seq_q    <= next_seq;
			handle_q <= next_handle;
		end else if (ctl.load) begin
			seq_q    <= load_seq;
			handle_q <= load_handle;
		end
	end

	assign seq    = seq_q;
	assign handle = handle_q;
	assign hit    = (seq_q == cmp_seq);

endmodule

@@ design/pending_request_tracker_unit.sv @@
// Top level of the pending request tracker: command capture, sequencer and cell row.
//
// Usage: drive action, seq_number and request_handle with start high; the
// command is transferred at a clock edge where start is high and busy is low.
// Insert appends at the tail (status full when all TABLE_DEPTH cells hold
// entries), find reports the oldest matching handle, remove deletes the oldest
// match and closes the gap, flush sends every stored handle oldest first.
// Each result is shown for one cycle with result_valid high; there is no
// back-pressure, the receiver must take it.
// Timing: insert, remove, find and an empty flush each give one result;
// busy stays high until that result is registered, so no new command is
// taken before it. A flush of N entries gives one result per cycle and
// keeps busy high until its last result is registered. This follows from
// the row of cells: all cells compare against the captured sequence
// number at once and the row shifts one position per cycle.
// Reset (arst_n low) empties the table and drops busy and result_valid;
// stored entries need no clearing, only cells below the fill count are read.
module pending_request_tracker_unit #(
	parameter int TABLE_DEPTH = 16,
	parameter int HANDLE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [prt_pkg::ACTION_W-1:0]      action,
	input  logic [prt_pkg::SEQ_W-1:0]         seq_number,
	input  logic [prt_pkg::HANDLE_IN_W-1:0]   request_handle,
	output logic                              result_valid,
	output logic [prt_pkg::STATUS_W-1:0]      status,
	output logic [prt_pkg::HANDLE_OUT_W-1:0]  handle_out,
	output logic                              is_flush_reply,
	output logic                              last,
	output logic [prt_pkg::COUNT_OUT_W-1:0]   entry_count
);
	import prt_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	state_t state_q;
	logic [CNT_W-1:0] fill_q, fill_d;

	// Captured command
	logic [ACTION_W-1:0]    cmd_action_q;
	logic [SEQ_W-1:0]       cmd_seq_q;
	logic [HANDLE_BITS-1:0] cmd_handle_q;
	logic [HANDLE_BITS-1:0] in_handle;

	// Result registers
	logic                    res_valid_q;
	logic [STATUS_W-1:0]     res_status_q;
	logic [HANDLE_OUT_W-1:0] res_handle_q;
	logic                    res_flush_q;
	logic                    res_last_q;
	logic [COUNT_OUT_W-1:0]  res_count_q;

	// Cell row
	cell_ctl_t              cell_ctl    [TABLE_DEPTH];
	logic [SEQ_W-1:0]       cell_seq    [TABLE_DEPTH];
	logic [HANDLE_BITS-1:0] cell_handle [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] cell_hit;
	logic [TABLE_DEPTH-1:0] in_use;
	logic [TABLE_DEPTH-1:0] hit_v, first_hit, from_first;
	logic                   any_hit, full;
	logic [HANDLE_BITS-1:0] sel_handle;
	logic [HANDLE_OUT_W-1:0] sel_handle_out, head_handle_out;
	logic [COUNT_OUT_W-1:0]  fill_d_out;

	logic accept, do_exec, do_flush;

	assign accept   = start && (state_q == ST_IDLE);
	assign do_exec  = (state_q == ST_EXEC);
	assign do_flush = (state_q == ST_FLUSH);
	assign busy     = (state_q != ST_IDLE);

	// Width adaption of handles and count
	generate
		if (HANDLE_BITS <= HANDLE_IN_W) begin : g_hin_narrow
			assign in_handle = request_handle[HANDLE_BITS-1:0];
		end else begin : g_hin_wide
			assign in_handle = {{(HANDLE_BITS-HANDLE_IN_W){1'b0}}, request_handle};
		end
		if (HANDLE_BITS >= HANDLE_OUT_W) begin : g_hout_narrow
			assign sel_handle_out  = sel_handle[HANDLE_OUT_W-1:0];
			assign head_handle_out = cell_handle[0][HANDLE_OUT_W-1:0];
		end else begin : g_hout_wide
			assign sel_handle_out  = {{(HANDLE_OUT_W-HANDLE_BITS){1'b0}}, sel_handle};
			assign head_handle_out = {{(HANDLE_OUT_W-HANDLE_BITS){1'b0}}, cell_handle[0]};
		end
		if (CNT_W >= COUNT_OUT_W) begin : g_cnt_narrow
			assign fill_d_out = fill_d[COUNT_OUT_W-1:0];
		end else begin : g_cnt_wide
			assign fill_d_out = {{(COUNT_OUT_W-CNT_W){1'b0}}, fill_d};
		end
	endgenerate

	// Match search: oldest in-use hit as a one-hot, and every cell from it onward
	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			in_use[i] = (CNT_W'(i) < fill_q);
		end
		hit_v      = cell_hit & in_use;
		first_hit  = hit_v & (~hit_v + TABLE_DEPTH'(1));
		from_first = ~(first_hit - TABLE_DEPTH'(1));
		any_hit    = |hit_v;
		full       = (fill_q == CNT_W'(TABLE_DEPTH));
		sel_handle = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			sel_handle = sel_handle | (cell_handle[i] & {HANDLE_BITS{first_hit[i]}});
		end
	end

	// Cell controls: insert loads the tail cell, remove and flush shift left
	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			cell_ctl[i].load  = do_exec && (cmd_action_q == ACT_INSERT) && !full
				&& (fill_q == CNT_W'(i));
			cell_ctl[i].shift = do_flush
				|| (do_exec && (cmd_action_q == ACT_REMOVE) && from_first[i]);
		end
	end

	// Next fill count
	always_comb begin
		fill_d = fill_q;
		if (do_exec) begin
			unique case (cmd_action_q)
				ACT_INSERT: if (!full) fill_d = fill_q + CNT_W'(1);
				ACT_REMOVE: if (any_hit) fill_d = fill_q - CNT_W'(1);
				ACT_FIND:   fill_d = fill_q;
				ACT_FLUSH:  fill_d = fill_q;
				default:    fill_d = fill_q;
			endcase
		end else if (do_flush) begin
			fill_d = fill_q - CNT_W'(1);
		end
	end

	// Sequencer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
		end else begin
			fill_q <= fill_d;
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_EXEC;
				ST_EXEC: begin
					if ((cmd_action_q == ACT_FLUSH) && (fill_q != '0)) begin
						state_q <= ST_FLUSH;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_FLUSH: if (fill_q == CNT_W'(1)) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Command capture on transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_action_q <= action;
			cmd_seq_q    <= seq_number;
			cmd_handle_q <= in_handle;
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= do_flush
				|| (do_exec && !((cmd_action_q == ACT_FLUSH) && (fill_q != '0)));
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (do_flush) begin
			res_status_q <= STAT_OK;
			res_handle_q <= head_handle_out;
			res_flush_q  <= 1'b1;
			res_last_q   <= (fill_q == CNT_W'(1));
			res_count_q  <= '0;
		end else if (do_exec) begin
			res_flush_q <= 1'b0;
			res_last_q  <= 1'b1;
			res_count_q <= fill_d_out;
			unique case (cmd_action_q)
				ACT_INSERT: begin
					res_status_q <= full ? STAT_FULL : STAT_OK;
					res_handle_q <= '0;
				end
				ACT_REMOVE, ACT_FIND: begin
					res_status_q <= any_hit ? STAT_OK : STAT_NOT_FOUND;
					res_handle_q <= any_hit ? sel_handle_out : '0;
				end
				ACT_FLUSH: begin
					res_status_q <= STAT_OK;
					res_handle_q <= '0;
				end
				default: begin
					res_status_q <= STAT_OK;
					res_handle_q <= '0;
				end
			endcase
		end
	end

	assign result_valid   = res_valid_q;
	assign status         = res_status_q;
	assign handle_out     = res_handle_q;
	assign is_flush_reply = res_flush_q;
	assign last           = res_last_q;
	assign entry_count    = res_count_q;

	// Row of cells, each fed by its right neighbor; the tail cell feeds itself
	generate
		for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
			localparam int NXT = (i == TABLE_DEPTH - 1) ? i : i + 1;
			prt_cell #(
				.HANDLE_BITS(HANDLE_BITS)
			) u_cell (
				.clk        (clk),
				.ctl        (cell_ctl[i]),
				.cmp_seq    (cmd_seq_q),
				.load_seq   (cmd_seq_q),
				.load_handle(cmd_handle_q),
				.next_seq   (cell_seq[NXT]),
				.next_handle(cell_handle[NXT]),
				.seq        (cell_seq[i]),
				.handle     (cell_handle[i]),
				.hit        (cell_hit[i])
			);
		end
	endgenerate

endmodule

@@ bench/tb_pending_request_tracker_unit.sv @@
// Self-checking bench for the pending request tracker: queued commands, live prediction, result checks.
module tb_pending_request_tracker_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import prt_pkg::*;

	localparam int DEPTH      = 16;
	localparam int RANDOM_CMDS = 370;

	typedef struct packed {
		logic [ACTION_W-1:0]    action;
		logic [SEQ_W-1:0]       seq;
		logic [HANDLE_IN_W-1:0] handle;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0]     st;
		logic [HANDLE_OUT_W-1:0] handle;
		logic                    flush_reply;
		logic                    last;
		logic [COUNT_OUT_W-1:0]  count;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [ACTION_W-1:0] action = ACT_INSERT;
	logic [SEQ_W-1:0] seq_number = '0;
	logic [HANDLE_IN_W-1:0] request_handle = '0;
	logic busy;
	logic result_valid;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_OUT_W-1:0] handle_out;
	logic is_flush_reply;
	logic last;
	logic [COUNT_OUT_W-1:0] entry_count;

	// Commands waiting to be driven, and the shadow list of sequence numbers used to plan them
	cmd_t cmd_queue[$];
	logic [SEQ_W-1:0] planned_seqs[$];
	int unsigned total_cmds = 0;
	int unsigned accepted_count = 0;

	// Predicted table contents and the replies still owed by the block
	logic [SEQ_W-1:0] tbl_seq[DEPTH];
	logic [HANDLE_IN_W-1:0] tbl_handle[DEPTH];
	int unsigned tbl_fill = 0;
	reply_t reply_queue[$];

	int unsigned error_count = 0;
	int unsigned hold_off = 0;
	int unsigned gap_len;
	bit no_idle_run = 1'b0;
	cmd_t next_cmd;
	reply_t got;
	reply_t want;

	pending_request_tracker_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.action         (action),
		.seq_number     (seq_number),
		.request_handle (request_handle),
		.result_valid   (result_valid),
		.status         (status),
		.handle_out     (handle_out),
		.is_flush_reply (is_flush_reply),
		.last           (last),
		.entry_count    (entry_count)
	);

	always #4 clk = ~clk;

	// Queue a command and keep the planning list of stored sequence numbers in step
	task automatic plan_cmd(logic [ACTION_W-1:0] op, logic [SEQ_W-1:0] seq,
			logic [HANDLE_IN_W-1:0] hnd);
		cmd_t c;
		c.action = op;
		c.seq    = seq;
		c.handle = hnd;
		cmd_queue.push_back(c);
		total_cmds++;
		case (op)
			ACT_INSERT: if (planned_seqs.size() < DEPTH) planned_seqs.push_back(seq);
			ACT_REMOVE: begin
				for (int i = 0; i < planned_seqs.size(); i++) begin
					if (planned_seqs[i] == seq) begin
						planned_seqs.delete(i);
						break;
					end
				end
			end
			ACT_FLUSH: planned_seqs.delete();
			default: ;
		endcase
	endtask

	// Mostly a narrow pool so duplicates and matches are common
	function automatic logic [SEQ_W-1:0] pick_seq();
		if ($urandom_range(3) == 0)
			return SEQ_W'($urandom_range(255));
		return SEQ_W'($urandom_range(15));
	endfunction

	// Sequence number that is stored most of the time, when anything is stored
	function automatic logic [SEQ_W-1:0] pick_lookup_seq();
		if (planned_seqs.size() > 0 && $urandom_range(3) != 0)
			return planned_seqs[$urandom_range(planned_seqs.size() - 1)];
		return pick_seq();
	endfunction

	// Idle cycles before the next command: mostly none or short, a few long
	function automatic int unsigned next_gap();
		int unsigned r;
		if ($urandom_range(39) == 0) no_idle_run = !no_idle_run;
		if (no_idle_run) return 0;
		r = $urandom_range(99);
		if (r < 45) return 0;
		if (r < 85) return $urandom_range(3, 1);
		if (r < 97) return $urandom_range(10, 4);
		return $urandom_range(40, 20);
	endfunction

	// Work out the replies a transferred command causes and update the predicted table
	function automatic void predict_replies(logic [ACTION_W-1:0] op, logic [SEQ_W-1:0] seq,
			logic [HANDLE_IN_W-1:0] hnd);
		int hit;
		reply_t r;
		hit = -1;
		r.st          = STAT_OK;
		r.handle      = '0;
		r.flush_reply = 1'b0;
		r.last        = 1'b1;
		r.count       = '0;
		case (op)
			ACT_INSERT: begin
				if (tbl_fill >= DEPTH) begin
					r.st = STAT_FULL;
				end else begin
					tbl_seq[tbl_fill]    = seq;
					tbl_handle[tbl_fill] = hnd;
					tbl_fill++;
				end
				r.count = COUNT_OUT_W'(tbl_fill);
				reply_queue.push_back(r);
			end
			ACT_REMOVE, ACT_FIND: begin
				for (int i = 0; i < tbl_fill; i++) begin
					if (hit < 0 && tbl_seq[i] == seq) hit = i;
				end
				if (hit < 0) begin
					r.st = STAT_NOT_FOUND;
				end else begin
					r.handle = tbl_handle[hit];
					if (op == ACT_REMOVE) begin
						// close the gap, order of the rest kept
						for (int i = hit; i + 1 < tbl_fill; i++) begin
							tbl_seq[i]    = tbl_seq[i + 1];
							tbl_handle[i] = tbl_handle[i + 1];
						end
						tbl_fill--;
					end
				end
				r.count = COUNT_OUT_W'(tbl_fill);
				reply_queue.push_back(r);
			end
			default: begin
				// flush: one flush reply per entry, oldest first; empty table gives one plain reply
				if (tbl_fill == 0) begin
					reply_queue.push_back(r);
				end else begin
					for (int i = 0; i < tbl_fill; i++) begin
						r.handle      = tbl_handle[i];
						r.flush_reply = 1'b1;
						r.last        = (i + 1 == tbl_fill);
						reply_queue.push_back(r);
					end
					tbl_fill = 0;
				end
			end
		endcase
	endfunction

	// Driver: one transfer per start/busy handshake, random idle between commands
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start    <= 1'b0;
			hold_off <= 0;
		end else if (start && !busy) begin
			predict_replies(action, seq_number, request_handle);
			accepted_count <= accepted_count + 1;
			gap_len = next_gap();
			if (gap_len == 0 && cmd_queue.size() > 0) begin
				next_cmd = cmd_queue.pop_front();
				start          <= 1'b1;
				action         <= next_cmd.action;
				seq_number     <= next_cmd.seq;
				request_handle <= next_cmd.handle;
			end else begin
				// junk on the idle inputs must be ignored
				start          <= 1'b0;
				hold_off       <= gap_len;
				action         <= ACTION_W'($urandom_range(3));
				seq_number     <= SEQ_W'($urandom_range(255));
				request_handle <= HANDLE_IN_W'($urandom_range(16'hFFFF));
			end
		end else if (!start) begin
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
			end else if (cmd_queue.size() > 0) begin
				next_cmd = cmd_queue.pop_front();
				start          <= 1'b1;
				action         <= next_cmd.action;
				seq_number     <= next_cmd.seq;
				request_handle <= next_cmd.handle;
			end
		end
	end

	// Monitor: every strobed result against the oldest predicted reply
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			got.st          = status;
			got.handle      = handle_out;
			got.flush_reply = is_flush_reply;
			got.last        = last;
			got.count       = entry_count;
			if (reply_queue.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("%0t: unexpected result st=%0d handle=%h flush=%b last=%b count=%0d",
						$realtime, got.st, got.handle, got.flush_reply, got.last, got.count);
			end else begin
				want = reply_queue.pop_front();
				if (got.st !== want.st || got.handle !== want.handle ||
						got.flush_reply !== want.flush_reply || got.last !== want.last ||
						got.count !== want.count) begin
					error_count++;
					if (error_count <= 10)
						$display("%0t: mismatch exp st=%0d handle=%h flush=%b last=%b count=%0d",
							$realtime,
							want.st, want.handle, want.flush_reply, want.last, want.count,
							" got st=%0d handle=%h flush=%b last=%b count=%0d",
							got.st, got.handle, got.flush_reply, got.last, got.count);
				end
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int unsigned r;

		// empty-table cases
		plan_cmd(ACT_FLUSH, 8'h00, 16'h0000);
		plan_cmd(ACT_FIND, 8'h00, 16'hFFFF);
		plan_cmd(ACT_REMOVE, 8'hFF, 16'h0000);
		// fill to the top: field extremes and a duplicated sequence number
		plan_cmd(ACT_INSERT, 8'h00, 16'h0000);
		plan_cmd(ACT_INSERT, 8'hFF, 16'hFFFF);
		plan_cmd(ACT_INSERT, 8'h55, 16'hAAAA);
		plan_cmd(ACT_INSERT, 8'h55, 16'h5555);
		for (int i = 4; i < DEPTH; i++)
			plan_cmd(ACT_INSERT, SEQ_W'(8'h20 + i), HANDLE_IN_W'($urandom_range(16'hFFFF)));
		// full table refuses, oldest duplicate found and removed first
		plan_cmd(ACT_INSERT, 8'hAA, 16'h1234);
		plan_cmd(ACT_FIND, 8'h55, 16'h0000);
		plan_cmd(ACT_REMOVE, 8'h55, 16'h0000);
		plan_cmd(ACT_FIND, 8'h55, 16'h0000);
		plan_cmd(ACT_REMOVE, 8'h13, 16'h0000);
		plan_cmd(ACT_FLUSH, 8'hFF, 16'hFFFF);

		// random traffic with occasional fill bursts up to and past full
		while (total_cmds < RANDOM_CMDS) begin
			r = $urandom_range(99);
			if (r < 5) begin
				while (planned_seqs.size() < DEPTH)
					plan_cmd(ACT_INSERT, pick_seq(), HANDLE_IN_W'($urandom_range(16'hFFFF)));
				repeat ($urandom_range(2, 1))
					plan_cmd(ACT_INSERT, pick_seq(), HANDLE_IN_W'($urandom_range(16'hFFFF)));
			end else if (r < 9) begin
				plan_cmd(ACT_FLUSH, pick_seq(), HANDLE_IN_W'($urandom_range(16'hFFFF)));
			end else if (r < 45) begin
				plan_cmd(ACT_INSERT, pick_seq(), HANDLE_IN_W'($urandom_range(16'hFFFF)));
			end else if (r < 70) begin
				plan_cmd(ACT_REMOVE, pick_lookup_seq(), HANDLE_IN_W'($urandom_range(16'hFFFF)));
			end else if (r < 95) begin
				plan_cmd(ACT_FIND, pick_lookup_seq(), HANDLE_IN_W'($urandom_range(16'hFFFF)));
			end else begin
				plan_cmd(ACT_INSERT + ACTION_W'($urandom_range(3)), SEQ_W'($urandom_range(255)),
					HANDLE_IN_W'($urandom_range(16'hFFFF)));
			end
		end

		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (accepted_count != total_cmds) @(posedge clk);
		while (reply_queue.size() != 0) @(posedge clk);
		// catch any result beyond the predicted ones
		repeat (40) @(posedge clk);

		if (error_count == 0)
			$display("pending_request_tracker_unit test passed");
		else
			$display("pending_request_tracker_unit test failed");
		$finish;
	end

	// Hard stop if the handshake or the result stream hangs
	initial begin
		#2_000_000;
		$display("pending_request_tracker_unit test failed");
		$finish;
	end

endmodule

@@ files.f @@
design/prt_pkg.sv
design/prt_cell.sv
design/pending_request_tracker_unit.sv
bench/tb_pending_request_tracker_unit.sv
